// ----- rtl/sum_tree_weighted_select_top_defines.svh -----
// ----------------------------------------------------------------------------
// sum tree weighted select - assertion macros
// shared assertion helpers for the rtl, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SUM_TREE_WEIGHTED_SELECT_TOP_DEFINES_SVH
`define SUM_TREE_WEIGHTED_SELECT_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define STWS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define STWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define STWS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define STWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/stws_pkg.sv -----
// ----------------------------------------------------------------------------
// stws_pkg
// shared types and constants of the sum tree weighted selector
// ----------------------------------------------------------------------------
`default_nettype none

package stws_pkg;

    // fixed field widths
    localparam int NODE_BITS  = 42;
    localparam int INDEX_BITS = 10;

    // operation codes
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_SET_UP,
        ST_FIND_DOWN,
        ST_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic set_start;
        logic set_step;
        logic find_start;
        logic find_step;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic op_find;
        logic at_root;
        logic find_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/stws_ctrl.sv -----
// ----------------------------------------------------------------------------
// stws_ctrl
// sequencer for clearing, leaf update ascent and target descent
// ----------------------------------------------------------------------------
`default_nettype none

`include "sum_tree_weighted_select_top_defines.svh"

module stws_ctrl
    import stws_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) n_state = ST_START;
            end
            ST_START: begin
                n_state = i_sts.op_find ? ST_FIND_DOWN : ST_SET_UP;
            end
            ST_SET_UP: begin
                if (i_sts.at_root) n_state = ST_FINISH;
            end
            ST_FIND_DOWN: begin
                if (i_sts.find_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            ST_START: begin
                o_cmd.find_start = i_sts.op_find;
                o_cmd.set_start  = !i_sts.op_find;
            end
            ST_SET_UP: begin
                o_cmd.set_step = 1'b1;
            end
            ST_FIND_DOWN: begin
                o_cmd.find_step = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // checks
    `STWS_ASSERT_NEXT(a_clear_ends, i_clk, i_rst_n,
        (r_state == ST_CLEAR) && i_sts.clear_last, r_state == ST_IDLE)
    `STWS_ASSERT_SAME(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free)
    `STWS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n,
        (r_state == ST_IDLE) && i_valid, r_state == ST_START)

endmodule

`default_nettype wire

// ----- rtl/stws_dp.sv -----
// ----------------------------------------------------------------------------
// stws_dp
// node memory, update and walk registers, and output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "sum_tree_weighted_select_top_defines.svh"

module stws_dp
    import stws_pkg::*;
#(
    parameter int LEAF_COUNT  = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_op,
    input  wire logic [INDEX_BITS-1:0] i_leaf_index,
    input  wire logic [NODE_BITS-1:0]  i_amount,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [INDEX_BITS-1:0]      o_found_index,
    output logic [NODE_BITS-1:0]       o_total,
    output logic                       o_total_zero
);

    localparam int LB       = $clog2(LEAF_COUNT);
    localparam int AW       = LB + 1;
    localparam int DEPTH    = 2 * LEAF_COUNT;
    localparam int CAP_BITS = (WEIGHT_BITS < NODE_BITS) ? WEIGHT_BITS : NODE_BITS;
    localparam logic [NODE_BITS-1:0] LEAF_CAP =
        (NODE_BITS'(1) << CAP_BITS) - NODE_BITS'(1);

    // node memory, index 0 unused, root at 1
    logic [NODE_BITS-1:0] r_mem [DEPTH];
    logic [NODE_BITS-1:0] r_rdata;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [NODE_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;

    // working registers
    logic                 r_op;
    logic [LB-1:0]        r_leaf;
    logic [NODE_BITS-1:0] r_amount;
    logic [AW-1:0]        r_node;
    logic [NODE_BITS-1:0] r_cur;
    logic [NODE_BITS-1:0] r_total;
    logic [AW-1:0]        r_clr;

    // output register
    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_found_index;
    logic [NODE_BITS-1:0]  r_out_total;
    logic                  r_out_zero;

    logic [NODE_BITS-1:0] leaf_weight;
    logic [NODE_BITS:0]   sum_wide;
    logic [NODE_BITS-1:0] sum_sat;
    logic [AW-1:0]        parent;
    logic                 go_left;
    logic [AW-1:0]        child;

    // leaf saturation, ancestor sum, descent decision
    assign leaf_weight = (r_amount > LEAF_CAP) ? LEAF_CAP : r_amount;
    assign sum_wide    = {1'b0, r_cur} + {1'b0, r_rdata};
    assign sum_sat     = sum_wide[NODE_BITS] ? '1 : sum_wide[NODE_BITS-1:0];
    assign parent      = {1'b0, r_node[AW-1:1]};
    assign go_left     = (r_amount <= r_rdata);
    assign child       = {r_node[AW-2:0], ~go_left};

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        if (i_cmd.clear_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
        end else if (i_cmd.set_start) begin
            mem_we    = 1'b1;
            mem_waddr = {1'b1, r_leaf};
            mem_wdata = leaf_weight;
            mem_raddr = {1'b1, r_leaf ^ LB'(1)};
        end else if (i_cmd.set_step) begin
            mem_we    = 1'b1;
            mem_waddr = parent;
            mem_wdata = sum_sat;
            mem_raddr = parent ^ AW'(1);
        end else if (i_cmd.find_start) begin
            mem_raddr = AW'(2);
        end else if (i_cmd.find_step) begin
            mem_raddr = {child[AW-2:0], 1'b0};
        end
    end

    // memory array
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // root total mirror
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.set_step && o_sts.at_root) begin
            r_total <= sum_sat;
        end
    end

    // item capture and tree walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_leaf   <= LB'(i_leaf_index);
            r_amount <= i_amount;
        end
        if (i_cmd.set_start) begin
            r_node <= {1'b1, r_leaf};
            r_cur  <= leaf_weight;
        end
        if (i_cmd.set_step) begin
            r_node <= parent;
            r_cur  <= sum_sat;
        end
        if (i_cmd.find_start) begin
            r_node <= AW'(1);
        end
        if (i_cmd.find_step) begin
            r_node <= child;
            if (!go_left) begin
                r_amount <= r_amount - r_rdata;
            end
        end
    end

    // result register toward the output side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_found_index <= (r_op == OP_FIND) ? INDEX_BITS'(r_node[LB-1:0]) : '0;
            r_out_total   <= r_total;
            r_out_zero    <= (r_total == '0);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found_index = r_found_index;
    assign o_total       = r_out_total;
    assign o_total_zero  = r_out_zero;

    // status toward the controller
    assign o_sts.clear_last = (r_clr == AW'(DEPTH - 1));
    assign o_sts.op_find    = (r_op == OP_FIND);
    assign o_sts.at_root    = (r_node[AW-1:1] == (AW-1)'(1));
    assign o_sts.find_last  = r_node[AW-2];
    assign o_sts.out_free   = !r_out_valid || i_ready;

    // checks
    `STWS_ASSERT_NEXT(a_find_reaches_leaf, i_clk, i_rst_n,
        i_cmd.find_step && o_sts.find_last, r_node[AW-1])
    `STWS_ASSERT_NEXT(a_root_tracks_sum, i_clk, i_rst_n,
        i_cmd.set_step && o_sts.at_root, (r_total == r_cur) && (r_node == AW'(1)))
    `STWS_ASSERT_NEXT(a_load_shows_total, i_clk, i_rst_n,
        i_cmd.load_out, o_valid && (o_total == r_total))

endmodule

`default_nettype wire

// ----- rtl/sum_tree_weighted_select_top.sv -----
// one item at a time: an input transfer is taken only in ST_IDLE, then the tree walk goes
//   one level per cycle through the single read and single write port of the node memory,
//   and the result is loaded into the output register before the next item is accepted
// reset: synchronous active low; a clearing pass then zeroes the node memory, during which
//   no input transfer is taken
`default_nettype none

// ----------------------------------------------------------------------------
// sum_tree_weighted_select_top
// binary sum tree over leaf weights with leaf update and weighted leaf search
// ----------------------------------------------------------------------------
module sum_tree_weighted_select_top
    import stws_pkg::*;
#(
    parameter int LEAF_COUNT  = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_op,
    input  wire logic [INDEX_BITS-1:0] i_leaf_index,
    input  wire logic [NODE_BITS-1:0]  i_amount,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [INDEX_BITS-1:0]      o_found_index,
    output logic [NODE_BITS-1:0]       o_total,
    output logic                       o_total_zero
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    stws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // tree memory and arithmetic
    stws_dp #(
        .LEAF_COUNT  (LEAF_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_leaf_index  (i_leaf_index),
        .i_amount      (i_amount),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found_index (o_found_index),
        .o_total       (o_total),
        .o_total_zero  (o_total_zero)
    );

endmodule

`default_nettype wire
